FILE: hw/rtl/sql_script_statement_splitter_defines.svh
// ----------------------------------------------------------------------------
// SQL statement splitter assertion macros
// Shared concurrent assertion helpers, clocked on clk, held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef SQL_SCRIPT_STATEMENT_SPLITTER_DEFINES_SVH
`define SQL_SCRIPT_STATEMENT_SPLITTER_DEFINES_SVH

// Property that must hold in the same cycle
`define SQLSPLIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the next cycle
`define SQLSPLIT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/sqlsplit_pkg.sv
// ----------------------------------------------------------------------------
// SQL statement splitter package
// Item types, character codes and sizing constants for the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqlsplit_pkg;

    // Character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Most results one input item can produce
    localparam int MAX_RESULTS = 3;

    // Default output queue depth (power of two, at least 4)
    localparam int RESULT_QUEUE_DEPTH = 4;

    // Input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       line_start;
        logic       end_of_file;
    } item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       stmt_end;
        logic       last_of_run;
    } result_t;

endpackage

FILE: hw/rtl/sql_script_statement_splitter.sv
// ----------------------------------------------------------------------------
// SQL script statement splitter
// Streams script bytes through, marks statement ends, strips comment lines
// and leading whitespace.
// ----------------------------------------------------------------------------
// Each accepted byte is scanned in the cycle it is accepted and its results
// (none to three) are written into a small output queue of QUEUE_DEPTH
// entries, which drains one result per cycle while result_stall is low. A
// byte is taken every cycle while the queue holds at most QUEUE_DEPTH-3
// results, so with the output free the input runs at one byte per cycle
// as long as bytes make one result or fewer; a byte that makes two or three
// results (a statement end, a line-start dash, the close at end of file)
// fills the queue faster than its single read port drains it. Results are
// registered in the output queue before they reach the result output.
`timescale 1ns / 1ps

`include "sql_script_statement_splitter_defines.svh"

module sql_script_statement_splitter #(
    parameter int QUEUE_DEPTH = sqlsplit_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Script byte input
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sqlsplit_pkg::item_t   item,
    // Result output
    output logic                  result_valid,
    input  logic                  result_stall,
    output sqlsplit_pkg::result_t result
);
    import sqlsplit_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_STRING = 3'd1,
        MODE_CLOSED = 3'd2,
        MODE_DASH   = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    // Scanner state
    mode_t           mode_reg,  mode_next;
    logic            qd_reg,    qd_next;
    logic            text_reg,  text_next;

    // Output queue
    result_t         queue_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;

    logic            accept;
    logic            pop;

    // Normal-scan decode
    logic [7:0]      c;
    logic            ls;
    logic            is_blank;
    logic            is_quote;
    logic [7:0]      open_quote;
    logic            nrm_dash;
    logic            nrm_emit;
    logic            nrm_end;
    mode_t           nrm_mode;
    logic            nrm_qd;
    logic            nrm_text;

    // Results of this item, in output order
    logic            e_dash;
    logic            e_char;
    logic            e_end;
    logic            e_eof;
    logic [1:0]      nres;
    logic [PtrW-1:0] a_char;
    logic [PtrW-1:0] a_end;
    logic [PtrW-1:0] a_eof;

    // Handshake
    assign item_stall   = count_reg > CntW'(QUEUE_DEPTH - MAX_RESULTS);
    assign accept       = item_valid && !item_stall;
    assign result_valid = count_reg != '0;
    assign pop          = result_valid && !result_stall;
    assign result       = queue_mem[rd_ptr_reg];

    assign c          = item.in_char;
    assign ls         = item.line_start;
    assign open_quote = qd_reg ? CH_DQUOTE : CH_SQUOTE;

    // Scan of a byte in normal mode
    always_comb
    begin
        is_blank = c inside {8'h20, [8'h09:8'h0D]};
        is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
        nrm_dash = ls && (c == CH_DASH);
        nrm_emit = !nrm_dash && (is_quote || (c == CH_SEMI) || text_reg || !is_blank);
        nrm_end  = !nrm_dash && !is_quote && (c == CH_SEMI);
        nrm_qd   = qd_reg;
        nrm_text = text_reg;
        nrm_mode = MODE_NORMAL;
        if (nrm_dash)
        begin
            nrm_mode = MODE_DASH;
        end
        else if (is_quote)
        begin
            nrm_mode = MODE_STRING;
            nrm_qd   = (c == CH_DQUOTE);
            nrm_text = 1'b1;
        end
        else if (c == CH_SEMI)
        begin
            nrm_text = 1'b0;
        end
        else
        begin
            nrm_text = text_reg || nrm_emit;
        end
    end

    // Per-mode scan and end-of-file close
    always_comb
    begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        text_next = text_reg;
        e_dash    = 1'b0;
        e_char    = 1'b0;
        e_end     = 1'b0;
        case (mode_reg)
            MODE_DASH:
            begin
                if (c == CH_DASH)
                begin
                    mode_next = MODE_SKIP;
                end
                else
                begin
                    e_dash    = 1'b1;
                    e_char    = 1'b1;
                    text_next = 1'b1;
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_SKIP:
            begin
                if (ls)
                begin
                    e_char    = nrm_emit;
                    e_end     = nrm_end;
                    mode_next = nrm_mode;
                    qd_next   = nrm_qd;
                    text_next = nrm_text;
                end
            end
            MODE_STRING:
            begin
                e_char    = 1'b1;
                text_next = 1'b1;
                if (c == open_quote)
                begin
                    mode_next = MODE_CLOSED;
                end
            end
            MODE_CLOSED:
            begin
                if (c == open_quote)
                begin
                    e_char    = 1'b1;
                    mode_next = MODE_STRING;
                end
                else
                begin
                    e_char    = nrm_emit;
                    e_end     = nrm_end;
                    mode_next = nrm_mode;
                    qd_next   = nrm_qd;
                    text_next = nrm_text;
                end
            end
            default:
            begin
                e_char    = nrm_emit;
                e_end     = nrm_end;
                mode_next = nrm_mode;
                qd_next   = nrm_qd;
                text_next = nrm_text;
            end
        endcase

        // End of file closes a statement with text, then back to reset state
        e_eof = item.end_of_file && text_next;
        if (item.end_of_file)
        begin
            mode_next = MODE_NORMAL;
            qd_next   = 1'b0;
            text_next = 1'b0;
        end
    end

    // Queue slots for this item's results
    assign nres   = 2'(e_dash) + 2'(e_char) + 2'(e_end) + 2'(e_eof);
    assign a_char = wr_ptr_reg + PtrW'(e_dash);
    assign a_end  = a_char + PtrW'(e_char);
    assign a_eof  = a_end + PtrW'(e_end);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg - CntW'(pop);
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + PtrW'(nres);
            count_next  = count_reg + CntW'(nres) - CntW'(pop);
        end
    end

    // State and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            qd_reg     <= 1'b0;
            text_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                qd_reg   <= qd_next;
                text_reg <= text_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; last_of_run goes on the final result of the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (e_dash)
            begin
                queue_mem[wr_ptr_reg] <= '{out_char: CH_DASH, stmt_end: 1'b0,
                                           last_of_run: 1'b0};
            end
            if (e_char)
            begin
                queue_mem[a_char] <= '{out_char: c, stmt_end: 1'b0,
                                       last_of_run: !e_end && !e_eof};
            end
            if (e_end)
            begin
                queue_mem[a_end] <= '{out_char: 8'h00, stmt_end: 1'b1,
                                      last_of_run: !e_eof};
            end
            if (e_eof)
            begin
                queue_mem[a_eof] <= '{out_char: 8'h00, stmt_end: 1'b1,
                                      last_of_run: 1'b1};
            end
        end
    end

    // Checks
    `SQLSPLIT_ASSERT(a_count_bound, count_reg <= CntW'(QUEUE_DEPTH), "result queue overflow")
    `SQLSPLIT_ASSERT(a_end_no_byte, !(result_valid && result.stmt_end) || result.out_char == 8'h00, "end marker carries a byte")
    `SQLSPLIT_ASSERT(a_string_text, !(mode_reg == MODE_STRING || mode_reg == MODE_CLOSED) || text_reg, "string open in empty statement")
    `SQLSPLIT_ASSERT_NEXT(a_eof_reset, accept && item.end_of_file, mode_reg == MODE_NORMAL && !text_reg && !qd_reg, "state not cleared after end of file")

endmodule
